// File: rtl/ps2mt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Types and constants shared by the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

    localparam int SIZE_W   = 13;
    localparam int POS_W    = 12;
    localparam int BTN_W    = 5;
    localparam int CODE_W   = 3;
    localparam int CFG_IDX_W = 2;

    // input modes
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_POLL = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_ENABLED = 2'd2;

    // first packet byte bit positions
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_SYNC   = 3;
    localparam int HDR_X_SIGN = 4;
    localparam int HDR_Y_SIGN = 5;

    // button codes
    localparam logic [CODE_W-1:0] BTN_NONE  = 3'd0;
    localparam logic [CODE_W-1:0] BTN_LEFT  = 3'd1;
    localparam logic [CODE_W-1:0] BTN_RIGHT = 3'd4;
    localparam logic [BTN_W-1:0]  WHEEL_UP   = 5'd8;
    localparam logic [BTN_W-1:0]  WHEEL_DOWN = 5'd16;

    localparam logic [1:0] LAST_IDX_PLAIN = 2'd2;
    localparam logic [1:0] LAST_IDX_WHEEL = 2'd3;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic              accepted;
        logic              valid_res;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [BTN_W-1:0]  buttons;
    } result_t;

    typedef struct packed {
        logic [SIZE_W-1:0] screen_width;
        logic [SIZE_W-1:0] screen_height;
        logic              wheel_enabled;
    } cfg_t;

endpackage

// File: rtl/ps2mt_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mt_stream_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface ps2mt_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/ps2mt_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mt_engine
// Tracker state and the per-item update: packet assembly, position and
// wheel accumulation with saturation, poll clamping and reporting.
// ----------------------------------------------------------------------------
module ps2mt_engine #(
    parameter int ACC_BITS  = 16,
    parameter int DEBT_BITS = 11
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ps2mt_pkg::cfg_t    cfg,
    input  logic               fire,
    input  ps2mt_pkg::item_t   item,
    output ps2mt_pkg::result_t result
);

    localparam int AW = ACC_BITS;
    localparam int DW = DEBT_BITS;
    localparam int SW = ((DW > 8) ? DW : 8) + 1;
    localparam int SZ = ps2mt_pkg::SIZE_W;
    localparam int PW = ps2mt_pkg::POS_W;

    logic [AW-1:0] acc_x_reg, acc_x_next;
    logic [AW-1:0] acc_y_reg, acc_y_next;
    logic          centred_reg, centred_next;
    logic [1:0]    byte_index_reg, byte_index_next;
    logic [7:0]    pkt_reg [0:2];
    logic [DW-1:0] debt_reg, debt_next;
    logic [ps2mt_pkg::CODE_W-1:0] code_reg, code_next;
    logic          moved_reg, moved_next;
    logic          held_reg, held_next;

    logic          screen;
    logic [AW-1:0] acc_x_cur, acc_y_cur;
    logic [1:0]    last_idx;
    logic          take_byte, finish, store;
    logic [7:0]    b0, b1, b2;
    logic [AW:0]   dx_ext, dy_ext, sum_x, sum_y;
    logic [AW-1:0] sat_x, sat_y;
    logic [SW-1:0] sum_d;
    logic [DW-1:0] sat_d;
    logic [ps2mt_pkg::CODE_W-1:0] new_code;
    logic [AW-1:0] w_ext, h_ext, clamp_x, clamp_y;
    logic          news;

    assign screen = (cfg.screen_width != '0) && (cfg.screen_height != '0);

    // centring happens on any item once a screen is configured
    assign acc_x_cur = (screen && !centred_reg)
                     ? {{(AW-SZ+1){1'b0}}, cfg.screen_width[SZ-1:1]} : acc_x_reg;
    assign acc_y_cur = (screen && !centred_reg)
                     ? {{(AW-SZ+1){1'b0}}, cfg.screen_height[SZ-1:1]} : acc_y_reg;

    assign last_idx  = cfg.wheel_enabled ? ps2mt_pkg::LAST_IDX_WHEEL
                                         : ps2mt_pkg::LAST_IDX_PLAIN;
    assign take_byte = (item.mode == ps2mt_pkg::MODE_BYTE) && screen && !held_reg;
    assign finish    = take_byte && (byte_index_reg >= last_idx);
    assign store     = take_byte && !finish;

    assign b0 = pkt_reg[0];
    assign b1 = pkt_reg[1];
    assign b2 = (byte_index_reg >= 2'd3) ? pkt_reg[2] : item.data_byte;

    // 9-bit deltas sign-extended to the accumulator sum width
    assign dx_ext = {{(AW-7){b0[ps2mt_pkg::HDR_X_SIGN]}}, b1};
    assign dy_ext = {{(AW-7){b0[ps2mt_pkg::HDR_Y_SIGN]}}, b2};
    assign sum_x  = {acc_x_cur[AW-1], acc_x_cur} + dx_ext;
    assign sum_y  = {acc_y_cur[AW-1], acc_y_cur} - dy_ext;

    always_comb
    begin
        if (sum_x[AW] != sum_x[AW-1])
            sat_x = sum_x[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        else
            sat_x = sum_x[AW-1:0];
        if (sum_y[AW] != sum_y[AW-1])
            sat_y = sum_y[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        else
            sat_y = sum_y[AW-1:0];
    end

    // wheel byte is a signed click count
    assign sum_d = {{(SW-DW){debt_reg[DW-1]}}, debt_reg}
                 + {{(SW-8){item.data_byte[7]}}, item.data_byte};

    always_comb
    begin
        if ((&sum_d[SW-1:DW-1]) || !(|sum_d[SW-1:DW-1]))
            sat_d = sum_d[DW-1:0];
        else
            sat_d = sum_d[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end

    always_comb
    begin
        if (b0[ps2mt_pkg::HDR_LEFT])
            new_code = ps2mt_pkg::BTN_LEFT;
        else if (b0[ps2mt_pkg::HDR_RIGHT])
            new_code = ps2mt_pkg::BTN_RIGHT;
        else
            new_code = ps2mt_pkg::BTN_NONE;
    end

    assign w_ext = {{(AW-SZ){1'b0}}, cfg.screen_width};
    assign h_ext = {{(AW-SZ){1'b0}}, cfg.screen_height};

    always_comb
    begin
        if (acc_x_cur[AW-1])
            clamp_x = '0;
        else if (acc_x_cur >= w_ext)
            clamp_x = w_ext - {{(AW-1){1'b0}}, 1'b1};
        else
            clamp_x = acc_x_cur;
        if (acc_y_cur[AW-1])
            clamp_y = '0;
        else if (acc_y_cur >= h_ext)
            clamp_y = h_ext - {{(AW-1){1'b0}}, 1'b1};
        else
            clamp_y = acc_y_cur;
    end

    assign news = moved_reg || (debt_reg != '0);

    always_comb
    begin
        acc_x_next      = acc_x_cur;
        acc_y_next      = acc_y_cur;
        centred_next    = centred_reg || screen;
        byte_index_next = byte_index_reg;
        debt_next       = debt_reg;
        code_next       = code_reg;
        moved_next      = moved_reg;
        held_next       = held_reg;
        result          = '0;

        if (item.mode == ps2mt_pkg::MODE_BYTE)
        begin
            result.accepted = take_byte;
            if (store)
                byte_index_next = byte_index_reg + 2'd1;
            if (finish)
            begin
                byte_index_next = 2'd0;
                if (b0[ps2mt_pkg::HDR_SYNC])
                begin
                    acc_x_next = sat_x;
                    acc_y_next = sat_y;
                    moved_next = 1'b1;
                    if (cfg.wheel_enabled)
                        debt_next = sat_d;
                    if (new_code != code_reg)
                    begin
                        code_next = new_code;
                        held_next = 1'b1;
                    end
                end
            end
        end
        else if (screen)
        begin
            held_next = 1'b0;
            if (news)
            begin
                acc_x_next       = clamp_x;
                acc_y_next       = clamp_y;
                moved_next       = 1'b0;
                result.valid_res = 1'b1;
                result.pos_x     = (|clamp_x[AW-1:PW]) ? {PW{1'b1}} : clamp_x[PW-1:0];
                result.pos_y     = (|clamp_y[AW-1:PW]) ? {PW{1'b1}} : clamp_y[PW-1:0];
                result.buttons   = {2'b00, code_reg};
                if (debt_reg[DW-1])
                begin
                    result.buttons = {2'b00, code_reg} | ps2mt_pkg::WHEEL_UP;
                    debt_next      = debt_reg + {{(DW-1){1'b0}}, 1'b1};
                end
                else if (debt_reg != '0)
                begin
                    result.buttons = {2'b00, code_reg} | ps2mt_pkg::WHEEL_DOWN;
                    debt_next      = debt_reg - {{(DW-1){1'b0}}, 1'b1};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
            centred_reg    <= 1'b0;
            byte_index_reg <= 2'd0;
            debt_reg       <= '0;
            code_reg       <= ps2mt_pkg::BTN_NONE;
            moved_reg      <= 1'b0;
            held_reg       <= 1'b0;
        end
        else if (fire)
        begin
            acc_x_reg      <= acc_x_next;
            acc_y_reg      <= acc_y_next;
            centred_reg    <= centred_next;
            byte_index_reg <= byte_index_next;
            debt_reg       <= debt_next;
            code_reg       <= code_next;
            moved_reg      <= moved_next;
            held_reg       <= held_next;
        end
    end

    // packet bytes carry no reset; only entries written this packet are read
    always_ff @(posedge clk)
    begin
        if (fire && store)
        begin
            case (byte_index_reg)
                2'd0:    pkt_reg[0] <= item.data_byte;
                2'd1:    pkt_reg[1] <= item.data_byte;
                2'd2:    pkt_reg[2] <= item.data_byte;
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/ps2_mouse_packet_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// An item passes through the input register, then the result register.
// Throughput: one item per cycle while the output is not stalled; the
// tracker state updates in the single pass between the two registers.
// Reset clears control state, configuration and the position, wheel and
// button state; packet byte storage is not reset.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker #(
    parameter int ACC_BITS  = 16,
    parameter int DEBT_BITS = 11
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    ps2mt_stream_if.sink                           in,
    ps2mt_stream_if.source                         out,
    input  logic                                   cfg_we,
    input  logic [ps2mt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ps2mt_pkg::SIZE_W-1:0]           cfg_data
);

    ps2mt_pkg::cfg_t    cfg_reg;
    ps2mt_pkg::item_t   item_reg;
    ps2mt_pkg::result_t result_reg;
    ps2mt_pkg::result_t result_next;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               proc_fire;

    // the pass fires when the result register is free or being drained
    assign proc_fire = in_valid_reg && (!out_valid_reg || out.ready);
    assign in.ready  = !in_valid_reg || proc_fire;

    assign out.valid   = out_valid_reg;
    assign out.payload = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ps2mt_pkg::REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data;
                ps2mt_pkg::REG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data;
                ps2mt_pkg::REG_WHEEL_ENABLED: cfg_reg.wheel_enabled <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in.ready)
                in_valid_reg <= in.valid;
            if (proc_fire)
                out_valid_reg <= 1'b1;
            else if (out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in.ready && in.valid)
            item_reg <= in.payload;
        if (proc_fire)
            result_reg <= result_next;
    end

    ps2mt_engine #(
        .ACC_BITS  (ACC_BITS),
        .DEBT_BITS (DEBT_BITS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .fire   (proc_fire),
        .item   (item_reg),
        .result (result_next)
    );

    // a byte result never carries a sample, a poll result never an accept
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(result_reg.accepted && result_reg.valid_res))
        else $error("result both accepted and valid");

    // report fields stay zero without a sample
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_reg.valid_res) |->
            (result_reg.buttons == '0 && result_reg.pos_x == '0
             && result_reg.pos_y == '0))
        else $error("report fields set without a sample");

    // a waiting item is kept until the pass takes it
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !proc_fire) |=> (in_valid_reg && $stable(item_reg)))
        else $error("input item lost while stalled");

    // a new result is only loaded once the previous one was taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out.ready) |-> !proc_fire)
        else $error("result overwritten before it was taken");

endmodule
